FILE: hw/rtl/utf8p_pkg.sv
// shared types and constants of the utf-8 decoder with position tracking
package utf8p_pkg;

  localparam int DATA_BYTE_BITS = 8;
  localparam int CODE_BITS      = 31;
  localparam int FIELD_BITS     = 32;
  localparam int TAKEN_BITS     = 3;
  localparam int TDATA_OUT_BITS = 128;

  // error run for one sequence: its lead error, then one error per continuation byte taken
  typedef struct packed {
    logic                    en;
    logic [FIELD_BITS-1:0]   start_off;
    logic [FIELD_BITS-1:0]   line_no;
    logic [FIELD_BITS-1:0]   col_no;
    logic [TAKEN_BITS-1:0]   taken;
  } fail_run_t;

  // one character or one single error
  typedef struct packed {
    logic                    en;
    logic [CODE_BITS-1:0]    cp;
    logic                    valid;
    logic [FIELD_BITS-1:0]   off;
    logic [FIELD_BITS-1:0]   line_no;
    logic [FIELD_BITS-1:0]   col_no;
  } single_t;

  // everything one input byte gives, in emission order a, s, b
  typedef struct packed {
    fail_run_t a;
    single_t   s;
    fail_run_t b;
  } job_t;

  typedef struct packed {
    logic [CODE_BITS-1:0]  code_point;
    logic                  char_valid;
    logic [FIELD_BITS-1:0] char_offset;
    logic [FIELD_BITS-1:0] line_number;
    logic [FIELD_BITS-1:0] column_number;
    logic                  run_last;
  } result_t;

endpackage

FILE: hw/rtl/utf8p_front.sv
// front end: takes bytes, tracks the decode state and builds at most one job per byte
module utf8p_front #(
  parameter int OFFSET_BITS   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [utf8p_pkg::DATA_BYTE_BITS-1:0] data_byte,
  input  logic                                 end_of_buffer,
  input  logic                                 queue_full,
  output logic                                 push,
  output utf8p_pkg::job_t                      job
);

  logic [OFFSET_BITS-1:0]          byte_position, byte_position_next;
  logic [POSITION_BITS-1:0]        line_count, line_count_next;
  logic [POSITION_BITS-1:0]        column_count, column_count_next;
  logic                            text_flag, text_flag_next;
  logic [2:0]                      pend_rem, pend_rem_next;
  logic [2:0]                      pend_taken, pend_taken_next;
  logic [utf8p_pkg::CODE_BITS-1:0] pend_value, pend_value_next;
  logic [OFFSET_BITS-1:0]          pend_start, pend_start_next;

  logic                            accept;
  logic                            is_cont;
  logic                            do_lead;
  logic                            lead_text;
  logic                            adv_en;
  logic [utf8p_pkg::CODE_BITS-1:0] adv_cp;
  logic [utf8p_pkg::FIELD_BITS-1:0] line32, col32;

  assign in_ready = !queue_full;
  assign accept   = in_valid && !queue_full;
  assign is_cont  = (data_byte[7:6] == 2'b10);
  assign line32   = utf8p_pkg::FIELD_BITS'(line_count);
  assign col32    = utf8p_pkg::FIELD_BITS'(column_count);

  always_comb begin
    byte_position_next = byte_position + OFFSET_BITS'(1);
    line_count_next    = line_count;
    column_count_next  = column_count;
    text_flag_next     = text_flag;
    pend_rem_next      = pend_rem;
    pend_taken_next    = pend_taken;
    pend_value_next    = pend_value;
    pend_start_next    = pend_start;
    job                = '0;
    do_lead            = 1'b1;
    lead_text          = text_flag;
    adv_en             = 1'b0;
    adv_cp             = '0;

    if (pend_rem != 3'd0) begin
      if (is_cont) begin
        // continuation extends the pending sequence
        do_lead         = 1'b0;
        pend_value_next = {pend_value[utf8p_pkg::CODE_BITS-7:0], data_byte[5:0]};
        pend_taken_next = pend_taken + 3'd1;
        pend_rem_next   = pend_rem - 3'd1;
        if (pend_rem == 3'd1) begin
          job.s.en        = 1'b1;
          job.s.cp        = pend_value_next;
          job.s.valid     = 1'b1;
          job.s.off       = utf8p_pkg::FIELD_BITS'(pend_start);
          job.s.line_no   = text_flag ? line32 : '0;
          job.s.col_no    = text_flag ? col32 : '0;
          adv_en          = text_flag;
          adv_cp          = pend_value_next;
          pend_taken_next = 3'd0;
          pend_value_next = '0;
        end
      end else begin
        // broken sequence: error run, then the byte starts afresh
        job.a.en        = 1'b1;
        job.a.start_off = utf8p_pkg::FIELD_BITS'(pend_start);
        job.a.line_no   = text_flag ? line32 : '0;
        job.a.col_no    = text_flag ? col32 : '0;
        job.a.taken     = pend_taken;
        lead_text       = 1'b0;
        text_flag_next  = 1'b0;
        pend_rem_next   = 3'd0;
        pend_taken_next = 3'd0;
        pend_value_next = '0;
      end
    end

    if (do_lead) begin
      unique case (data_byte) inside
        [8'h00:8'h7F]: begin
          job.s.en      = 1'b1;
          job.s.cp      = utf8p_pkg::CODE_BITS'(data_byte);
          job.s.valid   = 1'b1;
          job.s.off     = utf8p_pkg::FIELD_BITS'(byte_position);
          job.s.line_no = lead_text ? line32 : '0;
          job.s.col_no  = lead_text ? col32 : '0;
          adv_en        = lead_text;
          adv_cp        = utf8p_pkg::CODE_BITS'(data_byte);
        end
        [8'h80:8'hBF], 8'hFE, 8'hFF: begin
          job.s.en       = 1'b1;
          job.s.off      = utf8p_pkg::FIELD_BITS'(byte_position);
          job.s.line_no  = lead_text ? line32 : '0;
          job.s.col_no   = lead_text ? col32 : '0;
          text_flag_next = 1'b0;
        end
        [8'hC0:8'hDF]: begin
          pend_rem_next   = 3'd1;
          pend_value_next = utf8p_pkg::CODE_BITS'(data_byte[4:0]);
        end
        [8'hE0:8'hEF]: begin
          pend_rem_next   = 3'd2;
          pend_value_next = utf8p_pkg::CODE_BITS'(data_byte[3:0]);
        end
        [8'hF0:8'hF7]: begin
          pend_rem_next   = 3'd3;
          pend_value_next = utf8p_pkg::CODE_BITS'(data_byte[2:0]);
        end
        [8'hF8:8'hFB]: begin
          pend_rem_next   = 3'd4;
          pend_value_next = utf8p_pkg::CODE_BITS'(data_byte[1:0]);
        end
        default: begin
          pend_rem_next   = 3'd5;
          pend_value_next = utf8p_pkg::CODE_BITS'(data_byte[0]);
        end
      endcase
      if (pend_rem_next != 3'd0) begin
        pend_taken_next = 3'd0;
        pend_start_next = byte_position;
      end
    end

    // line and column move after a character, saturating
    if (adv_en) begin
      if (adv_cp == utf8p_pkg::CODE_BITS'(8'h0A)) begin
        if (line_count != '1) line_count_next = line_count + POSITION_BITS'(1);
        column_count_next = '0;
      end else if (column_count != '1) begin
        column_count_next = column_count + POSITION_BITS'(1);
      end
    end

    if (end_of_buffer) begin
      // cut-off sequence: text flag of the pending lead equals lead_text here
      if (pend_rem_next != 3'd0) begin
        job.b.en        = 1'b1;
        job.b.start_off = utf8p_pkg::FIELD_BITS'(pend_start_next);
        job.b.line_no   = lead_text ? line32 : '0;
        job.b.col_no    = lead_text ? col32 : '0;
        job.b.taken     = pend_taken_next;
      end
      byte_position_next = '0;
      line_count_next    = POSITION_BITS'(1);
      column_count_next  = '0;
      text_flag_next     = 1'b1;
      pend_rem_next      = 3'd0;
      pend_taken_next    = 3'd0;
      pend_value_next    = '0;
      pend_start_next    = '0;
    end
  end

  assign push = accept && (job.a.en || job.s.en || job.b.en);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      line_count    <= POSITION_BITS'(1);
      column_count  <= '0;
      text_flag     <= 1'b1;
      pend_rem      <= 3'd0;
      pend_taken    <= 3'd0;
      pend_value    <= '0;
      pend_start    <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      text_flag     <= text_flag_next;
      pend_rem      <= pend_rem_next;
      pend_taken    <= pend_taken_next;
      pend_value    <= pend_value_next;
      pend_start    <= pend_start_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (pend_rem != 3'd0) |-> (({1'b0, pend_rem} + {1'b0, pend_taken}) <= 4'd5))
    else $error("pending sequence longer than six bytes");

  assert property (@(posedge clk) disable iff (rst)
    (pend_rem == 3'd0) |-> ((pend_taken == 3'd0) && (pend_value == '0)))
    else $error("leftover sequence state with nothing pending");

endmodule

FILE: hw/rtl/utf8p_job_fifo.sv
// two-entry queue of jobs between front and back end
module utf8p_job_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  utf8p_pkg::job_t job_in,
  input  logic            pop,
  output utf8p_pkg::job_t job_out,
  output logic            head_valid,
  output logic            full
);

  utf8p_pkg::job_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign job_out    = entries[rd_ptr];
  assign head_valid = (count != 2'd0);
  assign full       = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= job_in;
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job written into a full queue");

  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job taken from an empty queue");

endmodule

FILE: hw/rtl/utf8p_back.sv
// back end: walks the head job and sends its results one per cycle while res_ready allows
module utf8p_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  utf8p_pkg::job_t    head,
  input  logic               head_valid,
  output logic               pop,
  output logic               res_valid,
  input  logic               res_ready,
  output utf8p_pkg::result_t res
);

  typedef enum logic [2:0] {
    SEG_A = 3'b001,
    SEG_S = 3'b010,
    SEG_B = 3'b100
  } seg_t;

  localparam logic [utf8p_pkg::FIELD_BITS-1:0] OFF_MASK =
    (OFFSET_BITS >= utf8p_pkg::FIELD_BITS) ? '1 :
    utf8p_pkg::FIELD_BITS'((64'd1 << OFFSET_BITS) - 64'd1);

  seg_t                             seg, seg_next, eff;
  logic [utf8p_pkg::TAKEN_BITS-1:0] idx, idx_next;
  utf8p_pkg::fail_run_t             run;
  utf8p_pkg::result_t               r;
  logic                             last;
  logic                             load;

  always_comb begin
    if (seg == SEG_A && head.a.en)      eff = SEG_A;
    else if (seg != SEG_B && head.s.en) eff = SEG_S;
    else                                eff = SEG_B;
  end

  assign run = (eff == SEG_A) ? head.a : head.b;

  always_comb begin
    r        = '0;
    last     = 1'b0;
    seg_next = seg;
    idx_next = idx;
    unique case (eff)
      SEG_A, SEG_B: begin
        r.char_offset   = (run.start_off + utf8p_pkg::FIELD_BITS'(idx)) & OFF_MASK;
        r.line_number   = (idx == '0) ? run.line_no : '0;
        r.column_number = (idx == '0) ? run.col_no : '0;
        if (eff == SEG_A) begin
          last = (idx == run.taken) && !head.s.en && !head.b.en;
          if (idx == run.taken) begin
            seg_next = SEG_S;
            idx_next = '0;
          end else begin
            idx_next = idx + utf8p_pkg::TAKEN_BITS'(1);
          end
        end else begin
          last     = (idx == run.taken);
          idx_next = idx + utf8p_pkg::TAKEN_BITS'(1);
        end
      end
      SEG_S: begin
        r.code_point    = head.s.cp;
        r.char_valid    = head.s.valid;
        r.char_offset   = head.s.off;
        r.line_number   = head.s.line_no;
        r.column_number = head.s.col_no;
        last            = !head.b.en;
        seg_next        = SEG_B;
        idx_next        = '0;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    r.run_last = last;
  end

  assign load = head_valid && (!res_valid || res_ready);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg       <= SEG_A;
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        seg <= SEG_A;
        idx <= '0;
      end else if (load) begin
        seg <= seg_next;
        idx <= idx_next;
      end
      if (load)           res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= r;
  end

  assert property (@(posedge clk) disable iff (rst) (load && !last) |=> head_valid)
    else $error("job left the queue before its last result");

endmodule

FILE: hw/rtl/utf8_decoder_with_position_core.sv
// top level of the utf-8 decoder with byte offset, line and column tracking
//
// input stream s_axis: one buffer byte per transaction in s_axis_tdata, s_axis_tlast
// marks the final byte of a buffer; after it every counter and the decode state
// return to their reset values
// output stream m_axis: one decoded character or decode error per transaction;
// m_axis_tuser is 1 for a character and 0 for an error, m_axis_tlast marks the
// last result caused by one input byte (bytes inside a sequence cause none)
// the first result of an accepted byte passes through the job queue entry and then
// the back end output register before it appears on m_axis
// throughput: one byte per cycle while each byte gives at most one result and m_axis
// is ready; a byte that breaks or cuts off a sequence gives up to six results, one
// per cycle while m_axis is ready, and holds the input back once the two-entry job
// queue fills; the front end decides everything per byte combinationally; the back
// end expands each job through an output register, so a stalled m_axis_tready only
// stops the back end and the front keeps taking bytes until the queue is full
// reset (synchronous, active high) empties the queue and drops any result waiting
module utf8_decoder_with_position_core #(
  parameter int OFFSET_BITS   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // data_byte[7:0]
  input  logic [utf8p_pkg::DATA_BYTE_BITS-1:0] s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // code_point[30:0], char_offset[62:31], line_number[94:63],
  // column_number[126:95], zero pad[127]
  output logic [utf8p_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
  // char_valid[0]
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tlast
);

  // queue handshake between the two halves
  logic               push;
  logic               pop;
  logic               full;
  logic               head_valid;
  utf8p_pkg::job_t    job_in;
  utf8p_pkg::job_t    job_head;
  utf8p_pkg::result_t res;

  // per-byte decode, position counters and sequence state
  utf8p_front #(
    .OFFSET_BITS   (OFFSET_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .data_byte     (s_axis_tdata),
    .end_of_buffer (s_axis_tlast),
    .queue_full    (full),
    .push          (push),
    .job           (job_in)
  );

  // lets the front run ahead while an error run drains
  utf8p_job_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .job_in     (job_in),
    .pop        (pop),
    .job_out    (job_head),
    .head_valid (head_valid),
    .full       (full)
  );

  // one result per cycle into the output register while m_axis is ready
  utf8p_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (job_head),
    .head_valid (head_valid),
    .pop        (pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // pack the result fields, lowest first
  assign m_axis_tdata = {1'b0, res.column_number, res.line_number,
                         res.char_offset, res.code_point};
  assign m_axis_tuser = res.char_valid;
  assign m_axis_tlast = res.run_last;

endmodule
